FILE: sv/nbd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nbd_pkg
// Types and constants shared by the nested bundle deframer modules.
// ---------------------------------------------------------------------------
package nbd_pkg;

   // parse phases
   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_OP2       = 4'd1;
   localparam logic [3:0] PH_SEQ1      = 4'd2;
   localparam logic [3:0] PH_SEQ2      = 4'd3;
   localparam logic [3:0] PH_DC_FIRST  = 4'd4;
   localparam logic [3:0] PH_DC_SECOND = 4'd5;
   localparam logic [3:0] PH_WHOLE     = 4'd6;
   localparam logic [3:0] PH_LEN       = 4'd7;
   localparam logic [3:0] PH_LENHI     = 4'd8;
   localparam logic [3:0] PH_LENLO     = 4'd9;
   localparam logic [3:0] PH_MSG_FIRST = 4'd10;
   localparam logic [3:0] PH_MSG       = 4'd11;
   localparam logic [3:0] PH_MP_SIZE   = 4'd12;
   localparam logic [3:0] PH_SUB_OP1   = 4'd13;
   localparam logic [3:0] PH_SUB_OP2   = 4'd14;
   localparam logic [3:0] PH_SKIP      = 4'd15;

   // opcodes and markers
   localparam logic [15:0] OP_DATA     = 16'h0900;
   localparam logic [15:0] OP_MULTI    = 16'h0300;
   localparam logic [7:0]  BUNDLE_LOW  = 8'h00;
   localparam logic [7:0]  BUNDLE_HIGH = 8'h19;
   localparam logic [7:0]  LEN_ESCAPE  = 8'hFF;

   // result queue
   localparam int FIFO_DEPTH  = 4;
   localparam int MAX_RESULTS = 2;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = PTR_W + 1;

   typedef struct packed {
      logic [3:0]  parse_phase;
      logic [7:0]  top_opcode_low;
      logic        in_multipacket;
      logic [7:0]  block_left;
      logic [15:0] message_left;
      logic [7:0]  held_byte;
      logic [7:0]  length_high;
      logic        stopped;
   } nbd_state_type;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       message_first;
      logic       message_last;
      logic       malformed;
   } nbd_result_type;

endpackage
`default_nettype wire

FILE: sv/nested_bundle_deframer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nested_bundle_deframer
// Splits plaintext packet bytes into application message bytes.
// ---------------------------------------------------------------------------
//  channel  dir  bits                                       transaction
//  req_*    in   tdata[7:0] data_byte, [20:8] bytes_after    one packet byte
//                tuser packet_start
//  rsp_*    out  tdata message_byte, tlast message_last,     one message byte
//                tuser[0] message_first, tuser[1] malformed  or malformed flag
//
//  One packet byte is taken per cycle; the parser state and the result
//  queue are written at the same edge, so a byte's results can leave on
//  the next cycle. A byte gives up to two results; the four-entry result
//  queue drains one per cycle, and req_tready is low while it has fewer
//  than two free entries. Reset is synchronous and empties the queue; no
//  clearing pass is needed. A stalled rsp side holds the head result.
// ---------------------------------------------------------------------------
module nested_bundle_deframer #(
   parameter int MAX_PACKET_BYTES = 8192
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [7:0] data_byte, [20:8] bytes_after, rest zero
   input  wire logic        req_tuser,   // [0] packet_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] message_byte
   output logic             rsp_tlast,   // message_last
   output logic [1:0]       rsp_tuser    // [0] message_first, [1] malformed
);

   localparam int PtrW = nbd_pkg::PTR_W;
   localparam int CntW = nbd_pkg::CNT_W;

   nbd_pkg::nbd_state_type  state_ff, state_in, state_step;
   nbd_pkg::nbd_result_type res0, res1;
   logic [1:0]              res_count;

   nbd_pkg::nbd_result_type fifo_ff [nbd_pkg::FIFO_DEPTH];
   logic [PtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]         count_ff, count_in;

   logic                    req_fire;
   logic                    rsp_fire;
   logic [1:0]              push_n;
   nbd_pkg::nbd_result_type head;

   nbd_step #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_step (
      .state        (state_ff),
      .data_byte    (req_tdata[7:0]),
      .packet_start (req_tuser),
      .bytes_after  (req_tdata[20:8]),
      .state_next   (state_step),
      .res0         (res0),
      .res1         (res1),
      .res_count    (res_count)
   );

   // accept only while the queue has room for a full pair of results
   assign req_tready = (count_ff <=
                        CntW'(nbd_pkg::FIFO_DEPTH - nbd_pkg::MAX_RESULTS));
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign push_n     = req_fire ? res_count : 2'd0;

   // hold the parser state unless a byte is taken
   assign state_in  = req_fire ? state_step : state_ff;
   assign wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PtrW'(rsp_fire);
   assign count_in  = count_ff + CntW'(push_n) - CntW'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload: write the first result at the tail, the second behind it
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) fifo_ff[wr_ptr_ff] <= res0;
      if (push_n == 2'd2) fifo_ff[wr_ptr_ff + PtrW'(1)] <= res1;
   end

   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = head.message_byte;
   assign rsp_tlast  = head.message_last;
   assign rsp_tuser  = {head.malformed, head.message_first};

endmodule
`default_nettype wire

FILE: sv/nbd_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nbd_step
// Next-state and result logic for one packet byte.
// ---------------------------------------------------------------------------
module nbd_step #(
   parameter int MAX_PACKET_BYTES = 8192
) (
   input  wire nbd_pkg::nbd_state_type  state,
   input  wire logic [7:0]              data_byte,
   input  wire logic                    packet_start,
   input  wire logic [12:0]             bytes_after,
   output nbd_pkg::nbd_state_type       state_next,
   output nbd_pkg::nbd_result_type      res0,
   output nbd_pkg::nbd_result_type      res1,
   output logic [1:0]                   res_count
);

   localparam logic [16:0] MaxTotal = 17'(MAX_PACKET_BYTES);

   // start a message of the given length, wait for another length on a zero length, or drop out on an oversize length
   function automatic nbd_pkg::nbd_state_type begin_msg(
      input nbd_pkg::nbd_state_type s,
      input logic [15:0]            len,
      input logic [12:0]            scope,
      input logic                   in_block
   );
      nbd_pkg::nbd_state_type r;
      r = s;
      if (len > {3'b000, scope}) begin
         if (in_block) r.parse_phase = nbd_pkg::PH_SKIP;
         else          r.stopped     = 1'b1;
      end else if (len == 16'd0) begin
         r.parse_phase = nbd_pkg::PH_LEN;
      end else begin
         r.message_left = len;
         r.parse_phase  = nbd_pkg::PH_MSG_FIRST;
      end
      return r;
   endfunction

   nbd_pkg::nbd_state_type nxt;
   logic        fin;
   logic        in_block;
   logic [12:0] scope;
   logic        endf;
   logic [15:0] op;
   logic [15:0] ml;

   always_comb begin
      nxt       = state;
      res0      = '0;
      res1      = '0;
      res_count = 2'd0;
      fin       = 1'b0;
      in_block  = 1'b0;
      scope     = bytes_after;
      endf      = 1'b0;
      op        = {data_byte, state.top_opcode_low};
      ml        = state.message_left - 16'd1;

      if (packet_start) begin
         nxt                = '0;
         nxt.stopped        = (({4'b0000, bytes_after} + 17'd1) > MaxTotal);
         nxt.top_opcode_low = data_byte;
         nxt.parse_phase    = nbd_pkg::PH_OP2;
         fin                = 1'b1;
      end else if (state.parse_phase == nbd_pkg::PH_IDLE) begin
         fin = 1'b0;
      end else if (state.stopped) begin
         fin = 1'b1;
      end else begin
         fin      = 1'b1;
         in_block = state.in_multipacket && (state.parse_phase != nbd_pkg::PH_MP_SIZE);
         if (in_block) nxt.block_left = state.block_left - 8'd1;
         scope = in_block ? {5'b00000, nxt.block_left} : bytes_after;
         endf  = (scope == 13'd0) || (bytes_after == 13'd0);

         case (state.parse_phase)
            nbd_pkg::PH_OP2: begin
               if (op == nbd_pkg::OP_DATA) begin
                  nxt.parse_phase = nbd_pkg::PH_SEQ1;
               end else if (op == nbd_pkg::OP_MULTI) begin
                  nxt.in_multipacket = 1'b1;
                  nxt.block_left     = 8'd0;
                  nxt.parse_phase    = nbd_pkg::PH_MP_SIZE;
               end else begin
                  // fragments, control and unknown opcodes
                  nxt.stopped = 1'b1;
               end
            end
            nbd_pkg::PH_SEQ1: nxt.parse_phase = nbd_pkg::PH_SEQ2;
            nbd_pkg::PH_SEQ2: nxt.parse_phase = nbd_pkg::PH_DC_FIRST;
            nbd_pkg::PH_DC_FIRST: begin
               if (endf) begin
                  res0            = '{data_byte, 1'b1, 1'b1, 1'b0};
                  res_count       = 2'd1;
                  nxt.parse_phase = nbd_pkg::PH_SKIP;
               end else begin
                  nxt.held_byte   = data_byte;
                  nxt.parse_phase = nbd_pkg::PH_DC_SECOND;
               end
            end
            nbd_pkg::PH_DC_SECOND: begin
               if (state.held_byte == nbd_pkg::BUNDLE_LOW &&
                   data_byte == nbd_pkg::BUNDLE_HIGH) begin
                  nxt.parse_phase = nbd_pkg::PH_LEN;
               end else begin
                  res0            = '{state.held_byte, 1'b1, 1'b0, 1'b0};
                  res1            = '{data_byte, 1'b0, endf, 1'b0};
                  res_count       = 2'd2;
                  nxt.parse_phase = nbd_pkg::PH_WHOLE;
               end
            end
            nbd_pkg::PH_WHOLE: begin
               res0      = '{data_byte, 1'b0, endf, 1'b0};
               res_count = 2'd1;
            end
            nbd_pkg::PH_LEN: begin
               if (data_byte == nbd_pkg::LEN_ESCAPE) begin
                  if (scope < 13'd2) begin
                     res0        = '{8'h00, 1'b0, 1'b0, 1'b1};
                     res_count   = 2'd1;
                     nxt.stopped = 1'b1;
                  end else begin
                     nxt.parse_phase = nbd_pkg::PH_LENHI;
                  end
               end else begin
                  nxt = begin_msg(nxt, {8'h00, data_byte}, scope, in_block);
               end
            end
            nbd_pkg::PH_LENHI: begin
               nxt.length_high = data_byte;
               nxt.parse_phase = nbd_pkg::PH_LENLO;
            end
            nbd_pkg::PH_LENLO: begin
               nxt = begin_msg(nxt, {state.length_high, data_byte}, scope, in_block);
            end
            nbd_pkg::PH_MSG_FIRST, nbd_pkg::PH_MSG: begin
               nxt.message_left = ml;
               res0 = '{data_byte, (state.parse_phase == nbd_pkg::PH_MSG_FIRST),
                        (ml == 16'd0) || (bytes_after == 13'd0), 1'b0};
               res_count       = 2'd1;
               nxt.parse_phase = (ml == 16'd0) ? nbd_pkg::PH_LEN : nbd_pkg::PH_MSG;
            end
            nbd_pkg::PH_MP_SIZE: begin
               if (data_byte == 8'd0 || {5'b00000, data_byte} > bytes_after) begin
                  nxt.stopped = 1'b1;
               end else begin
                  nxt.block_left  = data_byte;
                  nxt.parse_phase = nbd_pkg::PH_SUB_OP1;
               end
            end
            nbd_pkg::PH_SUB_OP1: begin
               nxt.held_byte   = data_byte;
               nxt.parse_phase = nbd_pkg::PH_SUB_OP2;
            end
            nbd_pkg::PH_SUB_OP2: begin
               nxt.parse_phase = ({data_byte, state.held_byte} == nbd_pkg::OP_DATA &&
                                  scope >= 13'd2) ? nbd_pkg::PH_SEQ1 : nbd_pkg::PH_SKIP;
            end
            default: ;
         endcase
      end

      if (fin) begin
         // block used up: back to the next size byte
         if (in_block && nxt.block_left == 8'd0) nxt.parse_phase = nbd_pkg::PH_MP_SIZE;
         // last byte of the packet
         if (bytes_after == 13'd0) begin
            nxt.parse_phase    = nbd_pkg::PH_IDLE;
            nxt.stopped        = 1'b0;
            nxt.in_multipacket = 1'b0;
            nxt.block_left     = 8'd0;
         end
      end
      state_next = nxt;
   end

endmodule
`default_nettype wire

FILE: sv/nbd_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nbd_checker
// Port-level checks for the nested bundle deframer.
// ---------------------------------------------------------------------------
module nbd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [1:0]  rsp_tuser
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // a malformed flag carries no byte and no message marks
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 8'h00 && !rsp_tuser[0] && !rsp_tlast)
      else $error("malformed result carries message fields");

   // reset empties the result queue
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // no result appears without a transaction on the input side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result appeared without an input transaction");

endmodule

bind nested_bundle_deframer nbd_checker u_checker (.*);
`default_nettype wire
